/* sv/tmrc_pkg.sv */
// ----------------------------------------------------------------------------
// tmrc_pkg
// shared widths, types and register codes for the clipped tile mean block
// ----------------------------------------------------------------------------
package tmrc_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM) + 1;  // 13, holds MAX_DIM itself
  localparam int unsigned COORD_W = $clog2(MAX_DIM);      // 12
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned NUM_CH  = 4;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned CNT_W   = 25;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STEP_W  = $clog2(CH_W);
  localparam int unsigned CH_IDX_W = $clog2(NUM_CH);

  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

  localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = DIM_W'(480);
  localparam logic [DIM_W-1:0]   RST_TILE_SIZE    = DIM_W'(16);
  localparam logic [COORD_W-1:0] RST_TILE_X       = '0;
  localparam logic [COORD_W-1:0] RST_TILE_Y       = '0;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_TILE_SIZE    = 3'd2,
    REG_TILE_X       = 3'd3,
    REG_TILE_Y       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [DIM_W-1:0]   tile_size;
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
  } cfg_t;

  // per-frame totals handed from the accumulator to the divider
  // ch_sum[3] red, [2] green, [1] blue, [0] alpha
  typedef struct packed {
    logic [NUM_CH-1:0][SUM_W-1:0] ch_sum;
    logic [CNT_W-1:0]             tile_count;
  } frame_sums_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CHECK,
    B_DIV,
    B_HOLD
  } back_state_t;

endpackage

/* sv/tmrc_if.sv */
// ----------------------------------------------------------------------------
// tmrc_if
// valid/ready stream interfaces for pixels in and mean results out
// ----------------------------------------------------------------------------
interface tmrc_pix_if import tmrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_word;
  logic [COORD_W-1:0] pixel_col;
  logic [COORD_W-1:0] pixel_row;
  logic               frame_end;

  modport source (output valid, pixel_word, pixel_col, pixel_row, frame_end, input ready);
  modport sink   (input valid, pixel_word, pixel_col, pixel_row, frame_end, output ready);
endinterface

interface tmrc_mean_if import tmrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] mean_word;
  logic             empty_tile;

  modport source (output valid, mean_word, empty_tile, input ready);
  modport sink   (input valid, mean_word, empty_tile, output ready);
endinterface

/* sv/tmrc_front.sv */
// ----------------------------------------------------------------------------
// tmrc_front
// tile hit test and channel accumulation, one pixel per cycle while the queue is not full
// ----------------------------------------------------------------------------
module tmrc_front import tmrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tmrc_pix_if.sink          pix,
  input  cfg_t              cfg,
  input  logic              q_full,
  output logic              q_push,
  output frame_sums_t       q_data
);

  logic [NUM_CH-1:0][SUM_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;

  logic [DIM_W-1:0] x_lim, y_lim, x_end, y_end;
  logic [DIM_W:0]   x_end_raw, y_end_raw;
  logic             col_hit, row_hit, hit, accept;

  // clip tile end to the frame bound, bound itself clamped to MAX_DIM
  always_comb begin
    x_lim     = (cfg.image_width  > MAX_DIM_V) ? MAX_DIM_V : cfg.image_width;
    y_lim     = (cfg.image_height > MAX_DIM_V) ? MAX_DIM_V : cfg.image_height;
    x_end_raw = {2'b00, cfg.tile_x} + {1'b0, cfg.tile_size};
    y_end_raw = {2'b00, cfg.tile_y} + {1'b0, cfg.tile_size};
    x_end     = (x_end_raw > {1'b0, x_lim}) ? x_lim : x_end_raw[DIM_W-1:0];
    y_end     = (y_end_raw > {1'b0, y_lim}) ? y_lim : y_end_raw[DIM_W-1:0];
    col_hit   = (pix.pixel_col >= cfg.tile_x) && ({1'b0, pix.pixel_col} < x_end);
    row_hit   = (pix.pixel_row >= cfg.tile_y) && ({1'b0, pix.pixel_row} < y_end);
    hit       = col_hit && row_hit;
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc_nxt[c] = acc_r[c] + (hit ? SUM_W'(pix.pixel_word[c*CH_W +: CH_W]) : '0);
    end
    cnt_nxt = cnt_r + CNT_W'(hit);
  end

  assign pix.ready = !q_full;
  assign accept    = pix.valid && pix.ready;
  assign q_push    = accept && pix.frame_end;
  assign q_data    = '{ch_sum: acc_nxt, tile_count: cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      if (pix.frame_end) begin
        acc_r <= '0;
        cnt_r <= '0;
      end else begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

/* sv/tmrc_fifo.sv */
// ----------------------------------------------------------------------------
// tmrc_fifo
// two-entry queue of frame totals between accumulator and divider
// ----------------------------------------------------------------------------
module tmrc_fifo import tmrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  frame_sums_t push_data,
  input  logic        pop,
  output frame_sums_t pop_data,
  output logic        full,
  output logic        empty
);

  frame_sums_t entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  level_r, level_nxt;
  logic        do_push, do_pop;

  assign full     = (level_r == 2'd2);
  assign empty    = (level_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    level_nxt  = level_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/tmrc_back.sv */
// ----------------------------------------------------------------------------
// tmrc_back
// shared restoring divider producing the saturated per-channel means
// ----------------------------------------------------------------------------
module tmrc_back import tmrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  frame_sums_t q_data,
  output logic        q_pop,
  tmrc_mean_if.source res
);

  back_state_t state_r, state_nxt;

  logic [NUM_CH-1:0][SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [CH_IDX_W-1:0]          ch_r;
  logic [STEP_W-1:0]            step_r;
  logic [SUM_W-1:0]             rem_r;
  logic [NUM_CH-1:0][CH_W-1:0]  mean_r;
  logic                         empty_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_word_r;
  logic             out_empty_r;

  logic             load, sat_check, div_step, load_out, slot_free;
  logic             sat, fits, last_ch;
  logic [SUM_W:0]   sat_lim;
  logic [SUM_W-1:0] trial;

  assign slot_free = !out_valid_r || res.ready;
  assign sat_lim   = {cnt_r, CH_W'(0)};
  assign sat       = {1'b0, sum_r[ch_r]} >= sat_lim;
  assign trial     = SUM_W'(cnt_r) << step_r;
  assign fits      = rem_r >= trial;
  assign last_ch   = (ch_r == CH_IDX_W'(NUM_CH - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_data.tile_count == '0) ? B_HOLD : B_CHECK;
        end
      end
      B_CHECK: begin
        if (!sat) state_nxt = B_DIV;
        else if (last_ch) state_nxt = B_HOLD;
      end
      B_DIV: begin
        if (step_r == '0) state_nxt = last_ch ? B_HOLD : B_CHECK;
      end
      B_HOLD: begin
        if (slot_free) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    load      = 1'b0;
    sat_check = 1'b0;
    div_step  = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      B_IDLE:  load      = !q_empty;
      B_CHECK: sat_check = 1'b1;
      B_DIV:   div_step  = 1'b1;
      B_HOLD:  load_out  = slot_free;
      default: ;
    endcase
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r   <= q_data.ch_sum;
      cnt_r   <= q_data.tile_count;
      ch_r    <= '0;
      mean_r  <= '0;
      empty_r <= (q_data.tile_count == '0);
    end
    if (sat_check) begin
      rem_r  <= sum_r[ch_r];
      step_r <= STEP_W'(CH_W - 1);
      if (sat) begin
        mean_r[ch_r] <= '1;
        ch_r         <= ch_r + 1'b1;
      end
    end
    if (div_step) begin
      if (fits) rem_r <= rem_r - trial;
      mean_r[ch_r][step_r] <= fits;
      step_r <= step_r - 1'b1;
      if (step_r == '0) ch_r <= ch_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word_r  <= mean_r;
      out_empty_r <= empty_r;
    end
  end

  assign res.valid      = out_valid_r;
  assign res.mean_word  = out_word_r;
  assign res.empty_tile = out_empty_r;

endmodule

/* sv/tile_mean_rgba_clipped_core.sv */
// ----------------------------------------------------------------------------
// tile_mean_rgba_clipped_core
// per-channel mean of a clipped square tile of an rgba8888 frame
// ----------------------------------------------------------------------------
//
//  port        dir   kind           carries
//  in_pix      in    valid/ready    pixel_word, pixel_col, pixel_row, frame_end
//  out_mean    out   valid/ready    mean_word, empty_tile
//  psel..      in    apb write/rd   image_width, image_height, tile_size,
//                                   tile_x, tile_y at byte address 4*index
//
//  pixels are taken one per cycle unless the queue is full; the hit test and channel sums run in the
//  accumulator with no bubble, frame_end pixel included
//  a frame_end transfer queues the frame totals; the divider then runs one
//  saturation check and 8 quotient bits per channel (a saturated channel
//  skips its bits, an empty tile skips all) before out_mean goes valid from
//  its output register; out_mean back-pressure and frames already queued
//  ahead delay it
//  in_pix stalls only when two finished frames wait in the queue
//  rst_n is synchronous; it clears sums, queue, divider and output valid
//  and restores the register defaults
//
module tile_mean_rgba_clipped_core import tmrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tmrc_pix_if.sink          in_pix,
  tmrc_mean_if.source       out_mean,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t        cfg_r, cfg_nxt;
  reg_idx_t    reg_idx;
  logic        wr_en;

  logic        q_push, q_pop, q_full, q_empty;
  frame_sums_t q_wr_data, q_rd_data;

  // register index from the word address; low byte bits ignored
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  // write path, fields keep only their own width
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:  cfg_nxt.image_width  = pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_nxt.image_height = pwdata[DIM_W-1:0];
        REG_TILE_SIZE:    cfg_nxt.tile_size    = pwdata[DIM_W-1:0];
        REG_TILE_X:       cfg_nxt.tile_x       = pwdata[COORD_W-1:0];
        REG_TILE_Y:       cfg_nxt.tile_y       = pwdata[COORD_W-1:0];
        default: ;  // unmapped addresses take no write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= RST_IMAGE_WIDTH;
      cfg_r.image_height <= RST_IMAGE_HEIGHT;
      cfg_r.tile_size    <= RST_TILE_SIZE;
      cfg_r.tile_x       <= RST_TILE_X;
      cfg_r.tile_y       <= RST_TILE_Y;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read path
  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = DATA_W'(cfg_r.image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(cfg_r.image_height);
      REG_TILE_SIZE:    prdata = DATA_W'(cfg_r.tile_size);
      REG_TILE_X:       prdata = DATA_W'(cfg_r.tile_x);
      REG_TILE_Y:       prdata = DATA_W'(cfg_r.tile_y);
      default:          prdata = '0;
    endcase
  end

  // front: hit test and accumulation at full pixel rate unless the queue is full
  tmrc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .pix    (in_pix),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  // frame totals wait here so the accumulator waits on the divider only when two frames are queued
  tmrc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_data),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: shared divider and output register
  tmrc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .res     (out_mean)
  );

endmodule
